### hdl/button_debounce_long_hold_defines.svh
// ----------------------------------------------------------------------------
// Button debounce with long hold - assertion macros
// Shared wrappers for concurrent checks clocked on clk.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_HOLD_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_HOLD_DEFINES_SVH

// check outside reset
`define BDLH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that also holds while reset is applied
`define BDLH_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/bdlh_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce with long hold - package
// Shared widths, register indexes and structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdlh_pkg;

	localparam int TIME_W      = 32;
	localparam int LIMIT_W     = 16;
	localparam int MASK_W      = 4;
	localparam int QUERY_W     = 2;
	localparam int REG_IDX_W   = 3;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 56;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DEBOUNCE    = 3'd0,
		REG_LONG_HOLD_0 = 3'd1,
		REG_LONG_HOLD_1 = 3'd2,
		REG_LONG_HOLD_2 = 3'd3,
		REG_LONG_HOLD_3 = 3'd4
	} bdlh_reg_t;

	// input item held in the first stage
	typedef struct packed {
		logic               seed;
		logic [TIME_W-1:0]  now;
		logic [MASK_W-1:0]  raw;
		logic [QUERY_W-1:0] query;
	} bdlh_item_t;

	// per-item control broadcast to every button
	typedef struct packed {
		logic              en;
		logic              seed;
		logic [TIME_W-1:0] now;
	} bdlh_step_t;

	// per-button outcome of one item
	typedef struct packed {
		logic              pressed;
		logic              released;
		logic              long_edge;
		logic              down;
		logic              boot;
		logic [TIME_W-1:0] hold;
	} bdlh_chan_t;

endpackage

### hdl/bdlh_chan.sv
// ----------------------------------------------------------------------------
// Button debounce with long hold - one button
// Debounce timer, stable state and long-hold tracking for a single button.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdlh_chan
	import bdlh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  bdlh_step_t         step,
	input  logic               raw,
	input  logic [LIMIT_W-1:0] settle_lim,
	input  logic [LIMIT_W-1:0] long_hold_ms,
	output bdlh_chan_t         res
);

	logic              raw_last_q;
	logic              stable_q;
	logic              long_done_q;
	logic              boot_q;
	logic [TIME_W-1:0] change_time_q;
	logic [TIME_W-1:0] press_time_q;

	logic              raw_chg;
	logic              settled;
	logic              accept;
	logic              press_e;
	logic              rel_e;
	logic              long_e;
	logic              stable_n;
	logic              long_done_n;
	logic [TIME_W-1:0] change_diff;
	logic [TIME_W-1:0] press_diff;

	always_comb begin
		raw_chg     = raw != raw_last_q;
		change_diff = step.now - change_time_q;
		press_diff  = step.now - press_time_q;
		// a raw change restarts the timer, so only a zero debounce accepts it at once
		settled     = raw_chg ? (settle_lim == '0)
		                      : (change_diff >= {{(TIME_W-LIMIT_W){1'b0}}, settle_lim});
		accept      = settled && (raw != stable_q);
		press_e     = accept && raw;
		rel_e       = accept && !raw;
		long_e      = (long_hold_ms != '0) && stable_q && !accept && !long_done_q &&
		              (press_diff >= {{(TIME_W-LIMIT_W){1'b0}}, long_hold_ms});
		stable_n    = accept ? raw : stable_q;
		long_done_n = press_e ? 1'b0 : (long_done_q || long_e);

		if (step.seed) begin
			// seeded buttons that are down count as long-fired: nothing to report
			res.pressed   = 1'b0;
			res.released  = 1'b0;
			res.long_edge = 1'b0;
			res.down      = raw;
			res.boot      = raw;
			res.hold      = '0;
		end else begin
			res.pressed   = press_e;
			res.released  = rel_e;
			res.long_edge = long_e;
			res.down      = stable_n;
			res.boot      = boot_q;
			res.hold      = (stable_n && !long_done_n && !press_e) ? press_diff : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_last_q    <= 1'b0;
			stable_q      <= 1'b0;
			long_done_q   <= 1'b0;
			boot_q        <= 1'b0;
			change_time_q <= '0;
			press_time_q  <= '0;
		end else if (step.en) begin
			if (step.seed) begin
				raw_last_q    <= raw;
				stable_q      <= raw;
				long_done_q   <= raw;
				boot_q        <= raw;
				change_time_q <= step.now;
				press_time_q  <= step.now;
			end else begin
				if (raw_chg) begin
					raw_last_q    <= raw;
					change_time_q <= step.now;
				end
				if (press_e) begin
					press_time_q <= step.now;
				end
				stable_q    <= stable_n;
				long_done_q <= long_done_n;
			end
		end
	end

endmodule

### hdl/button_debounce_long_hold.sv
// ----------------------------------------------------------------------------
// Button debounce with long hold - top level
// Debounces a set of push buttons against a millisecond time stamp and
// reports press, release and one-shot long-hold edges.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_*       in         item: tuser = req_type, tdata = now_ms, raw_levels, query_button
// m_*       out        result: edges, down and boot masks, hold_ms
// cfg_*     in         register write: index, 16-bit data, always ready
//
// One item per cycle while the result is taken; items pass an input stage and a result stage.
// All buttons are evaluated in parallel by two subtract and compare pairs each.
// Reset clears the state and loads the register defaults.
// A stalled result holds the result stage; the input stage still takes an item
// while it is empty or its item moves on to the result stage.
`timescale 1ns / 1ps

module button_debounce_long_hold
	import bdlh_pkg::*;
#(
	parameter int BUTTONS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [31:0] now_ms, [35:32] raw_levels, [37:36] query_button, [39:38] zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [0] req_type
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [3:0] pressed_edges, [7:4] released_edges, [11:8] long_edges,
	// [15:12] down_mask, [19:16] boot_held_mask, [51:20] hold_ms, [55:52] zero
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_data
);

	localparam int NUM_LONG = 4;

	logic [LIMIT_W-1:0]   debounce_q;
	logic [LIMIT_W-1:0]   long_hold_q [NUM_LONG];

	bdlh_item_t           item_s1;
	logic                 valid_s1;
	logic [M_TDATA_W-1:0] data_s2;
	logic                 valid_s2;

	logic                 adv;
	bdlh_step_t           step;
	bdlh_chan_t           chan_res [BUTTONS];

	logic [MASK_W-1:0]    pe_w;
	logic [MASK_W-1:0]    re_w;
	logic [MASK_W-1:0]    le_w;
	logic [MASK_W-1:0]    down_w;
	logic [MASK_W-1:0]    boot_w;
	logic [TIME_W-1:0]    hold_w;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= 16'd30;
			long_hold_q[0] <= 16'd1000;
			long_hold_q[1] <= 16'd0;
			long_hold_q[2] <= 16'd0;
			long_hold_q[3] <= 16'd1000;
		end else if (cfg_valid && cfg_ready) begin
			case (bdlh_reg_t'(cfg_index))
				REG_DEBOUNCE:    debounce_q     <= cfg_data;
				REG_LONG_HOLD_0: long_hold_q[0] <= cfg_data;
				REG_LONG_HOLD_1: long_hold_q[1] <= cfg_data;
				REG_LONG_HOLD_2: long_hold_q[2] <= cfg_data;
				REG_LONG_HOLD_3: long_hold_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the result stage is free or draining
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.seed  <= !s_tuser;
			item_s1.now   <= s_tdata[TIME_W-1:0];
			item_s1.raw   <= s_tdata[TIME_W +: MASK_W];
			item_s1.query <= s_tdata[TIME_W+MASK_W +: QUERY_W];
		end
		if (adv) begin
			data_s2 <= {4'b0, hold_w, boot_w, down_w, le_w, re_w, pe_w};
		end
	end

	assign step.en   = adv;
	assign step.seed = item_s1.seed;
	assign step.now  = item_s1.now;

	// one unit per button; buttons past the register set read raw 0, long hold off
	for (genvar i = 0; i < BUTTONS; i++) begin : g_btn
		logic               raw_i;
		logic [LIMIT_W-1:0] limit_i;
		if (i < MASK_W) begin : g_wired
			assign raw_i   = item_s1.raw[i];
			assign limit_i = long_hold_q[i];
		end else begin : g_spare
			assign raw_i   = 1'b0;
			assign limit_i = '0;
		end
		bdlh_chan u_chan (
			.clk          (clk),
			.arst_n       (arst_n),
			.step         (step),
			.raw          (raw_i),
			.settle_lim   (debounce_q),
			.long_hold_ms (limit_i),
			.res          (chan_res[i])
		);
	end

	// masks only show the first four buttons
	for (genvar k = 0; k < MASK_W; k++) begin : g_mask
		if (k < BUTTONS) begin : g_on
			assign pe_w[k]   = chan_res[k].pressed;
			assign re_w[k]   = chan_res[k].released;
			assign le_w[k]   = chan_res[k].long_edge;
			assign down_w[k] = chan_res[k].down;
			assign boot_w[k] = chan_res[k].boot;
		end else begin : g_off
			assign pe_w[k]   = 1'b0;
			assign re_w[k]   = 1'b0;
			assign le_w[k]   = 1'b0;
			assign down_w[k] = 1'b0;
			assign boot_w[k] = 1'b0;
		end
	end

	// query past the last button gives zero
	always_comb begin
		hold_w = '0;
		for (int i = 0; i < BUTTONS; i++) begin
			if (int'(item_s1.query) == i) begin
				hold_w = chan_res[i].hold;
			end
		end
	end

endmodule

### hdl/bdlh_chk.sv
// ----------------------------------------------------------------------------
// Button debounce with long hold - port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_debounce_long_hold_defines.svh"

module bdlh_chk
	import bdlh_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// the valid flags clear asynchronously; the check looks from the next edge on
	`BDLH_ASSERT_RST(a_no_result_in_reset, !arst_n |=> !m_tvalid, "result valid during reset")

	`BDLH_ASSERT(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

	`BDLH_ASSERT(a_edges_exclusive, m_tvalid |-> (m_tdata[3:0] & m_tdata[7:4]) == 4'b0, "press and release together")

	`BDLH_ASSERT(a_long_needs_down, m_tvalid |-> ((m_tdata[11:8] & ~m_tdata[15:12]) | (m_tdata[11:8] & m_tdata[3:0])) == 4'b0, "long edge on a button not held")

endmodule

bind button_debounce_long_hold bdlh_chk u_bdlh_chk (.*);
